// File: rtl/core/mm4r_pkg.sv
// ----------------------------------------------------------------------------
// mm4r_pkg: shared types and constants of the 4x4 row multiplier
// Element and product widths, row and matrix types, command codes and the
// per-stage advance controls sent to the column lanes.
// ----------------------------------------------------------------------------
package mm4r_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int ROWS      = 4;
    localparam int ROW_W     = 2;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int PAIR_W    = SHIFT_W + 1;
    localparam int SUM_W     = SHIFT_W + 2;

    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef logic [LANES-1:0][ELEM_W-1:0] t_row;
    typedef logic [ROWS-1:0][LANES-1:0][ELEM_W-1:0] t_mat;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MUL  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic adv1;
        logic adv2;
    } t_lane_ctl;

endpackage

// File: rtl/core/mm4r_store.sv
// ----------------------------------------------------------------------------
// mm4r_store: right-hand matrix store
// Four rows of four elements in flip-flops, one row written per load
// request, the whole matrix visible to the lanes at once.
// ----------------------------------------------------------------------------
module mm4r_store import mm4r_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ROW_W-1:0] i_row,
    input  t_row             i_data,
    output t_mat             o_mat
);

    t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mat[i_row] <= i_data;
        end
    end

    assign o_mat = r_mat;

endmodule

// File: rtl/core/mm4r_lane.sv
// ----------------------------------------------------------------------------
// mm4r_lane: one result column
// Four registered products, scaled pair sums, then the final sum with
// saturation to the element width.
// ----------------------------------------------------------------------------
module mm4r_lane import mm4r_pkg::*; (
    input  logic              i_clk,
    input  t_lane_ctl         i_ctl,
    input  t_row              i_left,
    input  t_row              i_col,
    output logic [ELEM_W-1:0] o_sum,
    output logic              o_sat
);

    logic signed [PROD_W-1:0]        r_prod [LANES];
    logic signed [PROD_W-1:0]        n_prod [LANES];
    logic signed [PAIR_W-1:0]        r_pair [2];
    logic signed [PAIR_W-1:0]        n_pair [2];
    logic signed [SUM_W-1:0]         w_sum;
    logic        [SUM_W-ELEM_W:0]    w_hi;
    logic                            w_fits;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_prod[k] = $signed(i_left[k]) * $signed(i_col[k]);
        end
        for (int p = 0; p < 2; p++) begin
            n_pair[p] = PAIR_W'($signed(r_prod[2*p][PROD_W-1:FRAC_BITS]))
                      + PAIR_W'($signed(r_prod[2*p+1][PROD_W-1:FRAC_BITS]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_prod <= n_prod;
        end
        if (i_ctl.adv2) begin
            r_pair <= n_pair;
        end
    end

    assign w_sum  = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
    assign w_hi   = w_sum[SUM_W-1:ELEM_W-1];
    assign w_fits = (&w_hi) || !(|w_hi);
    assign o_sat  = !w_fits;

    always_comb begin
        if (w_fits) begin
            o_sum = w_sum[ELEM_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            o_sum = ELEM_MIN;
        end else begin
            o_sum = ELEM_MAX;
        end
    end

endmodule

// File: rtl/core/mm4r_merge.sv
// ----------------------------------------------------------------------------
// mm4r_merge: result merge and output register
// Collects the four lane results and their saturation flags into one
// result row and holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
module mm4r_merge import mm4r_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [ROW_W-1:0] i_row,
    input  t_row             i_sum,
    input  logic [LANES-1:0] i_sat,
    input  logic             i_out_ready,
    output logic             o_free,
    output logic             o_out_valid,
    output logic [ROW_W-1:0] o_row,
    output t_row             o_prod,
    output logic             o_saturated
);

    logic             r_valid;
    logic             n_valid;
    logic [ROW_W-1:0] r_row;
    t_row             r_prod;
    logic             r_sat;

    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = o_free ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_row  <= i_row;
            r_prod <= i_sum;
            r_sat  <= |i_sat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_row       = r_row;
    assign o_prod      = r_prod;
    assign o_saturated = r_sat;

endmodule

// File: rtl/core/matrix_multiply_4x4_rows_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_rows_top: 4x4 signed Q16.16 matrix product, one row
// per request
// A load request (command 0) writes one row of the right-hand matrix into
// the internal store and returns nothing. A multiply request (command 1)
// carries one row of the left-hand matrix and returns the matching result
// row: each column is the sum of the four products, each shifted right by
// 16 bits (rounding toward minus infinity), saturated to 32 bits, with one
// flag set when any column saturated. A request is taken every cycle, load or
// multiply in any mix unless the output stalls; a multiply result moves
// through product, pair-sum and output registers. The rate is set by the four
// column lanes, each with four 32x32 multipliers, working in parallel on the
// whole row. Every right-matrix row a multiply depends on must be loaded first.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_rows_top import mm4r_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_command,
    input  logic [ROW_W-1:0]         i_row_index,
    input  logic signed [ELEM_W-1:0] i_elem0,
    input  logic signed [ELEM_W-1:0] i_elem1,
    input  logic signed [ELEM_W-1:0] i_elem2,
    input  logic signed [ELEM_W-1:0] i_elem3,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ROW_W-1:0]         o_row_out,
    output logic signed [ELEM_W-1:0] o_prod0,
    output logic signed [ELEM_W-1:0] o_prod1,
    output logic signed [ELEM_W-1:0] o_prod2,
    output logic signed [ELEM_W-1:0] o_prod3,
    output logic                     o_saturated
);

    t_row             w_left;
    t_mat             w_mat;
    t_row             w_sum;
    logic [LANES-1:0] w_sat;
    t_row             w_prod;
    t_lane_ctl        w_ctl;
    logic             w_accept;
    logic             w_free3;
    logic             w_take2;
    logic             w_take1;

    logic             r_v1;
    logic             n_v1;
    logic             r_v2;
    logic             n_v2;
    logic [ROW_W-1:0] r_row1;
    logic [ROW_W-1:0] r_row2;

    assign w_left = {i_elem3, i_elem2, i_elem1, i_elem0};

    assign w_take2    = !r_v2 || w_free3;
    assign w_take1    = !r_v1 || w_take2;
    assign o_in_ready = w_take1;
    assign w_accept   = i_in_valid && w_take1;

    assign w_ctl.adv1 = w_take1;
    assign w_ctl.adv2 = w_take2;

    assign n_v1 = w_take1 ? (i_in_valid && (i_command == CMD_MUL)) : r_v1;
    assign n_v2 = w_take2 ? r_v1 : r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take1) begin
            r_row1 <= i_row_index;
        end
        if (w_take2) begin
            r_row2 <= r_row1;
        end
    end

    mm4r_store u_store (
        .i_clk  (i_clk),
        .i_we   (w_accept && (i_command == CMD_LOAD)),
        .i_row  (i_row_index),
        .i_data (w_left),
        .o_mat  (w_mat)
    );

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        t_row w_col;

        always_comb begin
            for (int k = 0; k < ROWS; k++) begin
                w_col[k] = w_mat[k][j];
            end
        end

        mm4r_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_left (w_left),
            .i_col  (w_col),
            .o_sum  (w_sum[j]),
            .o_sat  (w_sat[j])
        );
    end

    mm4r_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v2),
        .i_row       (r_row2),
        .i_sum       (w_sum),
        .i_sat       (w_sat),
        .i_out_ready (i_out_ready),
        .o_free      (w_free3),
        .o_out_valid (o_out_valid),
        .o_row       (o_row_out),
        .o_prod      (w_prod),
        .o_saturated (o_saturated)
    );

    assign o_prod0 = w_prod[0];
    assign o_prod1 = w_prod[1];
    assign o_prod2 = w_prod[2];
    assign o_prod3 = w_prod[3];

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: request-level check of the 4x4 Q16.16 row multiplier
// Loads right-hand rows and multiplies left-hand rows through the valid/ready
// request channel while the result side stalls at random. A local copy of
// the right-hand store predicts every result row, which is compared field by
// field as it leaves the block. Directed rows cover identity, saturation in
// both directions and rounding toward minus infinity; random rows follow, with
// one long result hold-off that backs up requests, and a run without stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mm4r_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        t_row             prod;
        logic             sat;
    } t_row_result;

    localparam int CYCLE_LIMIT   = 60000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF      = 60;

    localparam logic [ELEM_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [ELEM_W-1:0] Q_TWO   = 32'h0002_0000;
    localparam logic [ELEM_W-1:0] Q_HALF  = 32'h0000_8000;
    localparam logic [ELEM_W-1:0] RAW_ONE = 32'h0000_0001;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_command;
    logic [ROW_W-1:0]         i_row_index;
    logic signed [ELEM_W-1:0] i_elem0;
    logic signed [ELEM_W-1:0] i_elem1;
    logic signed [ELEM_W-1:0] i_elem2;
    logic signed [ELEM_W-1:0] i_elem3;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [ROW_W-1:0]         o_row_out;
    logic signed [ELEM_W-1:0] o_prod0;
    logic signed [ELEM_W-1:0] o_prod1;
    logic signed [ELEM_W-1:0] o_prod2;
    logic signed [ELEM_W-1:0] o_prod3;
    logic                     o_saturated;

    t_row        right_rows [ROWS];
    t_row_result pending_rows [$];
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          hold_cycles   = 0;
    bit          src_stall_en  = 1'b1;
    bit          sink_stall_en = 1'b1;

    matrix_multiply_4x4_rows_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_row_index (i_row_index),
        .i_elem0     (i_elem0),
        .i_elem1     (i_elem1),
        .i_elem2     (i_elem2),
        .i_elem3     (i_elem3),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row_out   (o_row_out),
        .o_prod0     (o_prod0),
        .o_prod1     (o_prod1),
        .o_prod2     (o_prod2),
        .o_prod3     (o_prod3),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_row make_row(input logic [ELEM_W-1:0] e0, e1, e2, e3);
        return {e3, e2, e1, e0};
    endfunction

    function automatic t_row_result predict_row_product(input logic [ROW_W-1:0] row,
                                                        input t_row left);
        t_row_result res;
        longint      acc;
        longint      term;
        res.row = row;
        res.sat = 1'b0;
        for (int j = 0; j < LANES; j++) begin
            acc = 0;
            for (int k = 0; k < LANES; k++) begin
                term = longint'($signed(left[k])) * longint'($signed(right_rows[k][j]));
                acc  = acc + (term >>> FRAC_BITS);
            end
            if (acc > longint'($signed(ELEM_MAX))) begin
                res.prod[j] = ELEM_MAX;
                res.sat     = 1'b1;
            end else if (acc < longint'($signed(ELEM_MIN))) begin
                res.prod[j] = ELEM_MIN;
                res.sat     = 1'b1;
            end else begin
                res.prod[j] = acc[ELEM_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0:       v = ELEM_MAX;
                    1:       v = ELEM_MIN;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = Q_ONE;
                endcase
            end
            default: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    task automatic send_request(input t_cmd cmd, input logic [ROW_W-1:0] row,
                                input t_row elems);
        if (src_stall_en && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_row_index <= row;
        i_elem0     <= elems[0];
        i_elem1     <= elems[1];
        i_elem2     <= elems[2];
        i_elem3     <= elems[3];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        t_cmd cmd;
        t_row elems;
        for (int k = 0; k < LANES; k++) elems[k] = rand_elem();
        cmd = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_MUL;
        send_request(cmd, ROW_W'($urandom_range(0, ROWS - 1)), elems);
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_identity_rows();
        for (int r = 0; r < ROWS; r++) begin
            t_row ident;
            ident    = '0;
            ident[r] = Q_ONE;
            send_request(CMD_LOAD, ROW_W'(r), ident);
        end
        send_request(CMD_MUL, 2'd0, make_row(ELEM_MAX, ELEM_MIN, '0, '1));
        send_request(CMD_MUL, 2'd3, make_row(RAW_ONE, '1, ELEM_MIN, ELEM_MAX));
        send_request(CMD_MUL, 2'd1, make_row(32'h5555_AAAA, 32'hAAAA_5555,
                                             32'h0F0F_F0F0, 32'hF0F0_0F0F));
        finish_phase();
    endtask

    task automatic test_saturation();
        send_request(CMD_LOAD, 2'd0, make_row(ELEM_MAX, '0, Q_ONE, ELEM_MIN));
        for (int r = 1; r < ROWS; r++) begin
            send_request(CMD_LOAD, ROW_W'(r), make_row(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        end
        send_request(CMD_MUL, 2'd1, make_row(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
        send_request(CMD_MUL, 2'd2, make_row(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
        send_request(CMD_MUL, 2'd0, make_row(Q_ONE, '0, '0, '0));
        send_request(CMD_MUL, 2'd3, make_row(Q_TWO, '0, '0, '0));
        finish_phase();
    endtask

    task automatic test_rounding();
        for (int r = 0; r < ROWS; r++) begin
            send_request(CMD_LOAD, ROW_W'(r), make_row(RAW_ONE, RAW_ONE, RAW_ONE, RAW_ONE));
        end
        send_request(CMD_MUL, 2'd2, make_row('1, '0, '0, '0));
        send_request(CMD_MUL, 2'd1, make_row(Q_HALF, Q_HALF, Q_HALF, Q_HALF));
        send_request(CMD_MUL, 2'd3, make_row('1, '1, '1, '1));
        finish_phase();
    endtask

    task automatic test_random_mix();
        repeat (240) send_random_request();
        finish_phase();
    endtask

    task automatic test_output_backpressure();
        @(negedge i_clk);
        hold_cycles = HOLD_OFF;
        @(posedge i_clk);
        repeat (80) send_random_request();
        finish_phase();
    endtask

    task automatic test_no_idle_stretch();
        src_stall_en  = 1'b0;
        sink_stall_en = 1'b0;
        repeat (80) send_random_request();
        finish_phase();
        src_stall_en  = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (sink_stall_en && $urandom_range(0, 99) < 12) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : track_requests
        t_row elems;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            elems = {i_elem3, i_elem2, i_elem1, i_elem0};
            if (t_cmd'(i_command) == CMD_LOAD) begin
                right_rows[i_row_index] = elems;
            end else begin
                pending_rows.push_back(predict_row_product(i_row_index, elems));
            end
        end
    end

    always @(posedge i_clk) begin : check_rows
        t_row_result want;
        t_row        got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result row %0d", o_row_out);
                error_count++;
            end else begin
                want = pending_rows.pop_front();
                got  = {o_prod3, o_prod2, o_prod1, o_prod0};
                if (o_row_out !== want.row) begin
                    $error("row_out: expected %0d, got %0d", want.row, o_row_out);
                    error_count++;
                end
                for (int j = 0; j < LANES; j++) begin
                    if (got[j] !== want.prod[j]) begin
                        $error("prod%0d: expected %h, got %h", j, want.prod[j], got[j]);
                        error_count++;
                    end
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0b, got %0b", want.sat, o_saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_LOAD;
        i_row_index = '0;
        i_elem0     = '0;
        i_elem1     = '0;
        i_elem2     = '0;
        i_elem3     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity_rows();
        test_saturation();
        test_rounding();
        test_random_mix();
        test_output_backpressure();
        test_no_idle_stretch();
        if (error_count == 0 && pending_rows.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
